@@ rtl/mep_pkg.sv @@
// shared types, constants and helper functions of the escape-time pixel engine
`default_nettype none
package mep_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 28;
  localparam int WORD_BITS   = 32;
  localparam int WIDE_BITS   = 66;
  localparam int ITER_BITS   = 16;
  localparam int STEP_BITS   = 31;
  localparam int QUEUE_DEPTH = 2;
  localparam int MU_FRAC     = 8;
  localparam int MU_BITS     = MU_FRAC + 3;
  localparam int DIV_STEPS   = MU_BITS - 1;
  localparam int PAL_LAST    = 4;

  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_RE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_IM = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_RE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_IM   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT     = 3'd4;

  localparam logic signed [WORD_BITS-1:0] RST_ORIGIN_RE = -32'sd671088640;
  localparam logic signed [WORD_BITS-1:0] RST_ORIGIN_IM = -32'sd268435456;
  localparam logic [STEP_BITS-1:0]        RST_STEP_RE   = 31'd489335;
  localparam logic [STEP_BITS-1:0]        RST_STEP_IM   = 31'd497102;
  localparam logic [ITER_BITS-1:0]        RST_LIMIT     = 16'd128;

  localparam logic signed [WIDE_BITS-1:0] SAT_HI = WIDE_BITS'(64'sh7FFF_FFFF);
  localparam logic signed [WIDE_BITS-1:0] SAT_LO = -SAT_HI - WIDE_BITS'(1);
  localparam logic signed [WIDE_BITS-1:0] ESC_THRESH = WIDE_BITS'(4) <<< FRAC_BITS;
  localparam logic [MU_BITS-1:0]          MU_FULL = MU_BITS'(PAL_LAST) << MU_FRAC;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
  } pix_t;

  typedef struct packed {
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [ITER_BITS-1:0] iterations;
    logic                 escaped;
  } res_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] c_re;
    logic signed [WORD_BITS-1:0] c_im;
  } point_t;

  typedef struct packed {
    logic pop;
    logic mul_en;
    logic upd_en;
    logic finish;
    logic div_en;
    logic load_out;
  } bk_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD,
    BK_DIV,
    BK_COL
  } bk_state_t;

  function automatic logic signed [WORD_BITS-1:0] sat32(input logic signed [WIDE_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] t;
    t = v;
    if (v > SAT_HI) t = SAT_HI;
    if (v < SAT_LO) t = SAT_LO;
    return t[WORD_BITS-1:0];
  endfunction

  // palette entry as {red, green, blue}
  function automatic logic [23:0] palette(input logic [2:0] k);
    logic [23:0] c;
    case (k)
      3'd0:    c = {8'd60, 8'd0, 8'd85};
      3'd1:    c = {8'd187, 8'd232, 8'd255};
      3'd2:    c = {8'd230, 8'd155, 8'd218};
      3'd3:    c = {8'd240, 8'd240, 8'd255};
      default: c = {8'd0, 8'd2, 8'd0};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] f);
    logic [16:0] s;
    s = 17'(a) * (17'd256 - 17'(f)) + 17'(b) * 17'(f);
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

@@ rtl/mandelbrot_escape_pixel.sv @@
// top level of the escape-time pixel engine: config registers and front/back hookup
`default_nettype none
// One pixel word goes in, one colour word comes out. The front end maps the
// coordinate to a point through a registered multiply and drops it into a
// two-entry queue, so it keeps taking pixels while the engine works, until the
// queue and the front register are both full. The engine runs one pixel at a
// time: each iteration goes through the shared squaring unit (multiply, then
// update and escape check), and an escaping pixel then goes through the
// bit-serial palette divider before its colour word is formed.
module mandelbrot_escape_pixel (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire mep_pkg::pix_t                         in_word,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output mep_pkg::res_t                              out_word,
  input  wire logic                                  cfg_we,
  input  wire logic [mep_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [mep_pkg::WORD_BITS-1:0]         cfg_wdata
);

  logic signed [mep_pkg::WORD_BITS-1:0] origin_re_r, origin_im_r;
  logic [mep_pkg::STEP_BITS-1:0]        step_re_r, step_im_r;
  logic [mep_pkg::ITER_BITS-1:0]        limit_r;

  logic            push, full, pop, nonempty;
  mep_pkg::point_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= mep_pkg::RST_ORIGIN_RE;
      origin_im_r <= mep_pkg::RST_ORIGIN_IM;
      step_re_r   <= mep_pkg::RST_STEP_RE;
      step_im_r   <= mep_pkg::RST_STEP_IM;
      limit_r     <= mep_pkg::RST_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        mep_pkg::CFG_ORIGIN_RE: origin_re_r <= cfg_wdata;
        mep_pkg::CFG_ORIGIN_IM: origin_im_r <= cfg_wdata;
        mep_pkg::CFG_STEP_RE:   step_re_r   <= cfg_wdata[mep_pkg::STEP_BITS-1:0];
        mep_pkg::CFG_STEP_IM:   step_im_r   <= cfg_wdata[mep_pkg::STEP_BITS-1:0];
        mep_pkg::CFG_LIMIT:     limit_r     <= cfg_wdata[mep_pkg::ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  mep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .origin_re (origin_re_r),
    .origin_im (origin_im_r),
    .step_re   (step_re_r),
    .step_im   (step_im_r),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  mep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .nonempty  (nonempty)
  );

  mep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nonempty  (nonempty),
    .pop       (pop),
    .pop_data  (pop_data),
    .limit     (limit_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

@@ rtl/mep_front.sv @@
// front end: accepts pixel words and maps them to complex points
`default_nettype none
module mep_front (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire mep_pkg::pix_t                           in_word,
  input  wire logic signed [mep_pkg::WORD_BITS-1:0]    origin_re,
  input  wire logic signed [mep_pkg::WORD_BITS-1:0]    origin_im,
  input  wire logic [mep_pkg::STEP_BITS-1:0]           step_re,
  input  wire logic [mep_pkg::STEP_BITS-1:0]           step_im,
  input  wire logic                                    full,
  output logic                                         push,
  output mep_pkg::point_t                              push_data
);

  localparam int PROD_BITS = mep_pkg::COORD_BITS + mep_pkg::STEP_BITS;

  logic                 v_r, v_nxt;
  logic [PROD_BITS-1:0] pr_r, pi_r;
  logic                 take;
  logic signed [mep_pkg::WIDE_BITS-1:0] sum_re, sum_im;

  assign in_stall = v_r & full;
  assign take     = in_valid & ~in_stall;
  assign push     = v_r & ~full;
  assign v_nxt    = take | (v_r & full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pr_r <= PROD_BITS'(in_word.pixel_col) * PROD_BITS'(step_re);
      pi_r <= PROD_BITS'(in_word.pixel_row) * PROD_BITS'(step_im);
    end
  end

  always_comb begin
    sum_re = mep_pkg::WIDE_BITS'(origin_re) + $signed(mep_pkg::WIDE_BITS'(pr_r));
    sum_im = mep_pkg::WIDE_BITS'(origin_im) + $signed(mep_pkg::WIDE_BITS'(pi_r));
    push_data.c_re = mep_pkg::sat32(sum_re);
    push_data.c_im = mep_pkg::sat32(sum_im);
  end

endmodule
`default_nettype wire

@@ rtl/mep_queue.sv @@
// short point queue between front end and iteration engine
`default_nettype none
module mep_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mep_pkg::point_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output mep_pkg::point_t      pop_data,
  output logic                 nonempty
);

  localparam int PTR_BITS = $clog2(mep_pkg::QUEUE_DEPTH);

  mep_pkg::point_t     mem_r [mep_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_BITS:0]   count_r, count_nxt;

  assign full     = count_r == (PTR_BITS + 1)'(mep_pkg::QUEUE_DEPTH);
  assign nonempty = count_r != '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_BITS + 1)'(push) - (PTR_BITS + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mep_back.sv @@
// iteration engine, palette index divider and colour stage
`default_nettype none
module mep_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               nonempty,
  output logic                                    pop,
  input  wire mep_pkg::point_t                    pop_data,
  input  wire logic [mep_pkg::ITER_BITS-1:0]      limit,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output mep_pkg::res_t                           out_word
);

  localparam int W  = mep_pkg::WIDE_BITS;
  localparam int IB = mep_pkg::ITER_BITS;

  mep_pkg::bk_state_t state_r, state_nxt;
  mep_pkg::bk_ctl_t   ctl;

  logic signed [mep_pkg::WORD_BITS-1:0]   cr_r, ci_r, re_r, im_r;
  logic signed [2*mep_pkg::WORD_BITS-1:0] prr_r, pii_r, pri_r;
  logic [IB-1:0]                          cnt_r, it_r, rem_r, rem_next;
  logic                                   esc_r;
  logic [mep_pkg::MU_BITS-1:0]            mu_r;
  logic [3:0]                             dcnt_r;
  logic                                   out_valid_r, out_valid_nxt;
  mep_pkg::res_t                          out_r;

  logic signed [W-1:0] rr, ii, ri, sq_sum;
  logic                escape_hit, at_limit, div_last;
  logic [IB:0]         dtry;
  logic                dge;
  logic [2:0]          k, k2;
  logic [7:0]          f;
  logic [23:0]         pa, pb;

  always_comb begin
    rr         = W'(prr_r >>> mep_pkg::FRAC_BITS);
    ii         = W'(pii_r >>> mep_pkg::FRAC_BITS);
    ri         = W'(pri_r >>> mep_pkg::FRAC_BITS);
    sq_sum     = rr + ii;
    escape_hit = (cnt_r != '0) && (sq_sum > mep_pkg::ESC_THRESH);
    at_limit   = cnt_r == limit;
    dtry       = {rem_r, 1'b0};
    dge        = dtry >= {1'b0, limit};
    rem_next   = dge ? IB'(dtry - {1'b0, limit}) : IB'(dtry);
    div_last   = dcnt_r == 4'(mep_pkg::DIV_STEPS - 1);
    k          = mu_r[mep_pkg::MU_BITS-1:mep_pkg::MU_FRAC];
    f          = mu_r[mep_pkg::MU_FRAC-1:0];
    k2         = (k >= 3'(mep_pkg::PAL_LAST)) ? 3'(mep_pkg::PAL_LAST) : k + 3'd1;
    pa         = mep_pkg::palette(k);
    pb         = mep_pkg::palette(k2);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mep_pkg::BK_IDLE: begin
        if (nonempty) state_nxt = mep_pkg::BK_MUL;
      end
      mep_pkg::BK_MUL: begin
        state_nxt = mep_pkg::BK_UPD;
      end
      mep_pkg::BK_UPD: begin
        if (escape_hit) state_nxt = mep_pkg::BK_DIV;
        else if (at_limit) state_nxt = mep_pkg::BK_COL;
        else state_nxt = mep_pkg::BK_MUL;
      end
      mep_pkg::BK_DIV: begin
        if (div_last) state_nxt = mep_pkg::BK_COL;
      end
      mep_pkg::BK_COL: begin
        if (!out_valid_r || !out_stall) state_nxt = mep_pkg::BK_IDLE;
      end
      default: state_nxt = mep_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      mep_pkg::BK_IDLE: ctl.pop = nonempty;
      mep_pkg::BK_MUL:  ctl.mul_en = 1'b1;
      mep_pkg::BK_UPD: begin
        ctl.finish = escape_hit | at_limit;
        ctl.upd_en = ~(escape_hit | at_limit);
      end
      mep_pkg::BK_DIV:  ctl.div_en = 1'b1;
      mep_pkg::BK_COL:  ctl.load_out = ~out_valid_r | ~out_stall;
      default:          ctl = '0;
    endcase
  end

  assign pop           = ctl.pop;
  assign out_valid_nxt = ctl.load_out | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;
  assign out_word      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mep_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cr_r  <= pop_data.c_re;
      ci_r  <= pop_data.c_im;
      re_r  <= '0;
      im_r  <= '0;
      cnt_r <= '0;
    end
    if (ctl.mul_en) begin
      prr_r <= re_r * re_r;
      pii_r <= im_r * im_r;
      pri_r <= re_r * im_r;
    end
    if (ctl.upd_en) begin
      re_r  <= mep_pkg::sat32(rr - ii + W'(cr_r));
      im_r  <= mep_pkg::sat32((ri <<< 1) + W'(ci_r));
      cnt_r <= cnt_r + 1'b1;
    end
    if (ctl.finish) begin
      esc_r  <= escape_hit;
      it_r   <= escape_hit ? cnt_r - 1'b1 : cnt_r;
      rem_r  <= cnt_r - 1'b1;
      mu_r   <= escape_hit ? '0 : mep_pkg::MU_FULL;
      dcnt_r <= '0;
    end
    if (ctl.div_en) begin
      rem_r  <= rem_next;
      mu_r   <= {mu_r[mep_pkg::MU_BITS-2:0], dge};
      dcnt_r <= dcnt_r + 4'd1;
    end
    if (ctl.load_out) begin
      out_r.red        <= mep_pkg::mix(pa[23:16], pb[23:16], f);
      out_r.green      <= mep_pkg::mix(pa[15:8], pb[15:8], f);
      out_r.blue       <= mep_pkg::mix(pa[7:0], pb[7:0], f);
      out_r.iterations <= it_r;
      out_r.escaped    <= esc_r;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mep_pkg::BK_UPD |-> cnt_r <= limit)
    else $error("iteration count past limit");

  a_esc_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.escaped |-> out_r.iterations < limit)
    else $error("escaped word reports full count");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mep_pkg::BK_DIV |-> mu_r[mep_pkg::MU_BITS-1] == 1'b0)
    else $error("palette index overflow in divider");

endmodule
`default_nettype wire

@@ tb/mep_checker.sv @@
// checker for the escape-time pixel engine: predicts each colour word and compares
module mep_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  mep_pkg::pix_t                        in_word,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  mep_pkg::res_t                        out_word,
  input  logic                                 cfg_we,
  input  logic [mep_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mep_pkg::WORD_BITS-1:0]        cfg_wdata,
  output int                                   fail_count,
  output int                                   pending
);

  logic signed [31:0] org_re, org_im;
  logic [30:0]        stp_re, stp_im;
  logic [15:0]        iter_cap;
  mep_pkg::res_t      colour_q[$];

  localparam logic [23:0] PAL [0:4] = '{
    {8'd60, 8'd0, 8'd85}, {8'd187, 8'd232, 8'd255}, {8'd230, 8'd155, 8'd218},
    {8'd240, 8'd240, 8'd255}, {8'd0, 8'd2, 8'd0}};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> mep_pkg::FRAC_BITS;
  endfunction

  function automatic mep_pkg::res_t escape_colour(mep_pkg::pix_t p);
    longint cr, ci, re, im, nre, nim;
    int unsigned it, lim, m, k, k2, f;
    logic [23:0] pa, pb;
    mep_pkg::res_t r;
    cr = clamp32(longint'(org_re) + longint'(p.pixel_col) * longint'(stp_re));
    ci = clamp32(longint'(org_im) + longint'(p.pixel_row) * longint'(stp_im));
    re = 0;
    im = 0;
    lim = 32'(iter_cap);
    for (it = 0; it < lim; it++) begin
      nre = clamp32(fxmul(re, re) - fxmul(im, im) + cr);
      nim = clamp32(2 * fxmul(re, im) + ci);
      re = nre;
      im = nim;
      if (fxmul(re, re) + fxmul(im, im) > (64'sd4 <<< mep_pkg::FRAC_BITS)) break;
    end
    if (lim == 0) m = 4 << 8;
    else m = (it * 1024) / lim;
    k = m >> 8;
    if (k > 4) k = 4;
    f = m & 255;
    k2 = (k + 1 > 4) ? 4 : k + 1;
    pa = PAL[k];
    pb = PAL[k2];
    r.red = 8'((int'(pa[23:16]) * (256 - f) + int'(pb[23:16]) * f) >> 8);
    r.green = 8'((int'(pa[15:8]) * (256 - f) + int'(pb[15:8]) * f) >> 8);
    r.blue = 8'((int'(pa[7:0]) * (256 - f) + int'(pb[7:0]) * f) >> 8);
    r.iterations = it[15:0];
    r.escaped = (it < lim);
    return r;
  endfunction

  assign pending = colour_q.size();

  always @(posedge clk) begin
    mep_pkg::res_t exp_w;
    if (!rst_n) begin
      org_re <= mep_pkg::RST_ORIGIN_RE;
      org_im <= mep_pkg::RST_ORIGIN_IM;
      stp_re <= mep_pkg::RST_STEP_RE;
      stp_im <= mep_pkg::RST_STEP_IM;
      iter_cap <= mep_pkg::RST_LIMIT;
      colour_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mep_pkg::CFG_ORIGIN_RE: org_re <= cfg_wdata;
          mep_pkg::CFG_ORIGIN_IM: org_im <= cfg_wdata;
          mep_pkg::CFG_STEP_RE:   stp_re <= cfg_wdata[30:0];
          mep_pkg::CFG_STEP_IM:   stp_im <= cfg_wdata[30:0];
          mep_pkg::CFG_LIMIT:     iter_cap <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) colour_q.push_back(escape_colour(in_word));
      if (out_valid && !out_stall) begin
        if (colour_q.size() == 0) begin
          $error("unexpected word %h", out_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = colour_q.pop_front();
          if (exp_w != out_word) fail_count <= fail_count + 1;
          if (exp_w.red != out_word.red)
            $error("red exp %0d got %0d", exp_w.red, out_word.red);
          if (exp_w.green != out_word.green)
            $error("green exp %0d got %0d", exp_w.green, out_word.green);
          if (exp_w.blue != out_word.blue)
            $error("blue exp %0d got %0d", exp_w.blue, out_word.blue);
          if (exp_w.iterations != out_word.iterations)
            $error("iterations exp %0d got %0d", exp_w.iterations, out_word.iterations);
          if (exp_w.escaped != out_word.escaped)
            $error("escaped exp %0d got %0d", exp_w.escaped, out_word.escaped);
        end
      end
    end
  end
endmodule

@@ tb/tb_mandelbrot_escape_pixel.sv @@
// testbench top: drives pixel words and config writes, gives the verdict
module tb_mandelbrot_escape_pixel;

  logic                             clk = 0;
  logic                             rst_n = 0;
  logic                             in_valid = 0;
  logic                             in_stall;
  mep_pkg::pix_t                    in_word = '0;
  logic                             out_valid;
  logic                             out_stall = 0;
  mep_pkg::res_t                    out_word;
  logic                             cfg_we = 0;
  logic [mep_pkg::CFG_IDX_BITS-1:0] cfg_index = mep_pkg::CFG_ORIGIN_RE;
  logic [mep_pkg::WORD_BITS-1:0]    cfg_wdata = '0;
  int                               fail_count, pending;
  int                               gap_pct = 0, stall_pct = 0;

  always #5 clk = ~clk;

  mandelbrot_escape_pixel u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_we, .cfg_index, .cfg_wdata);

  mep_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending);

  always @(negedge clk) out_stall = ($urandom_range(99) < stall_pct);

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_word.pixel_col = col;
    in_word.pixel_row = row;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mep_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [31:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_all(input logic [31:0] ore, input logic [31:0] oim,
                         input logic [31:0] sre, input logic [31:0] sim,
                         input logic [31:0] lim);
    drain();
    write_reg(mep_pkg::CFG_ORIGIN_RE, ore);
    write_reg(mep_pkg::CFG_ORIGIN_IM, oim);
    write_reg(mep_pkg::CFG_STEP_RE, sre);
    write_reg(mep_pkg::CFG_STEP_IM, sim);
    write_reg(mep_pkg::CFG_LIMIT, lim);
  endtask

  task automatic random_phase(input int n);
    logic [31:0] ore, oim, sre, sim;
    if ($urandom_range(3) == 0) begin
      ore = $urandom;
      oim = $urandom;
      sre = $urandom;
      sim = $urandom;
    end else begin
      ore = -32'sd671088640 + $urandom_range(939524096);
      oim = -32'sd402653184 + $urandom_range(268435456);
      sre = $urandom_range(400000);
      sim = $urandom_range(400000);
    end
    set_all(ore, oim, sre, sim, $urandom_range(1, 64) | ($urandom & 32'hFFFF_0000));
    repeat (n) begin
      send_pixel(12'($urandom), 12'($urandom));
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    // reset window, corners and middle
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd1200, 12'd2100);
    // zero limit
    set_all(32'h0, 32'h0, 32'd0, 32'd0, 32'h0);
    send_pixel(12'd7, 12'd9);
    // single iteration, bits above the register width set
    set_all(32'hF000_0000, 32'h0800_0000, 32'hFFFF_FFFF, 32'h8000_1000, 32'hFFFF_0001);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    // coordinate saturation high, and the lowest coordinate value
    set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd20);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd4095);
    // large point that overflows the iterate
    set_all(32'h7F00_0000, 32'h7F00_0000, 32'd0, 32'd0, 32'd10);
    send_pixel(12'd1, 12'd1);
    // maximum limit: immediate escape, then a point at the origin
    set_all(-32'sd671088640, 32'h0, 32'd0, 32'd0, 32'd65535);
    send_pixel(12'd0, 12'd0);
    set_all(32'h0, 32'h0, 32'd0, 32'd0, 32'd65535);
    send_pixel(12'd0, 12'd0);
    // small steps along the real axis from a negative origin at a mid limit
    set_all(-32'sd536870912, 32'h0, 32'd100000, 32'd0, 32'd300);
    send_pixel(12'd100, 12'd0);
    send_pixel(12'd3000, 12'd0);

    gap_pct = 20;
    stall_pct = 57;
    random_phase(80);
    random_phase(80);
    gap_pct = 57;
    stall_pct = 20;
    random_phase(80);
    drain();
    random_phase(80);
    gap_pct = 0;
    stall_pct = 0;
    random_phase(80);
    random_phase(80);

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ mandelbrot_escape_pixel.f @@
rtl/mep_pkg.sv
rtl/mep_front.sv
rtl/mep_queue.sv
rtl/mep_back.sv
rtl/mandelbrot_escape_pixel.sv
tb/mep_checker.sv
tb/tb_mandelbrot_escape_pixel.sv
